@@ sv/ipi_mailbox_pending_dispatch_assert.svh @@
// ----------------------------------------------------------------------------
// ipi mailbox assertion macros
// concurrent assertion helpers clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef IPI_MAILBOX_PENDING_DISPATCH_ASSERT_SVH
`define IPI_MAILBOX_PENDING_DISPATCH_ASSERT_SVH

// same-cycle implication
`define IPIMB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipi mailbox same-cycle check failed");

// next-cycle implication
`define IPIMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipi mailbox next-cycle check failed");

`endif

@@ sv/ipimb_pkg.sv @@
// ----------------------------------------------------------------------------
// ipimb_pkg
// shared types and constants of the ipi mailbox
// ----------------------------------------------------------------------------
package ipimb_pkg;

  localparam int NUM_CPUS     = 8;
  localparam int NUM_MESSAGES = 32;
  localparam int CPU_W        = 3;
  localparam int MSG_W        = 32;
  localparam int IDX_W        = $clog2(MSG_W);
  localparam int CNT_W        = 6;
  localparam int SENT_W       = 3;

  typedef enum logic [1:0] {
    REQ_REGISTER  = 2'd0,
    REQ_SEND      = 2'd1,
    REQ_BROADCAST = 2'd2,
    REQ_DISPATCH  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_FULL       = 3'd2,
    ST_OFFLINE    = 3'd3,
    ST_RAISE_FAIL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec_op;
    logic load_scan;
    logic emit_scan;
  } cmd_t;

  typedef struct packed {
    logic is_dispatch;
    logic slot_free;
    logic scan_last;
  } sts_t;

endpackage

@@ sv/ipimb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ipimb_ctrl
// request sequencer: capture, execute, then scan out dispatch results
// ----------------------------------------------------------------------------
module ipimb_ctrl import ipimb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_dispatch) begin
          state_nxt = S_SCAN;
        end else if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.slot_free && sts.scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.load_scan = sts.is_dispatch;
        cmd.exec_op   = !sts.is_dispatch && sts.slot_free;
      end
      S_SCAN: begin
        cmd.emit_scan = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/ipimb_dp.sv @@
// ----------------------------------------------------------------------------
// ipimb_dp
// mailbox datapath: pending words, slot count, per-cpu lanes, result register
// ----------------------------------------------------------------------------
module ipimb_dp import ipimb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                cfg_valid,
  input  logic [NUM_CPUS-1:0] cfg_online_mask,
  input  logic [1:0]          in_req_type,
  input  logic [CPU_W-1:0]    in_cpu,
  input  logic [MSG_W-1:0]    in_msg_bits,
  input  logic [NUM_CPUS-1:0] in_raise_fail_mask,
  input  logic                in_args_valid,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [MSG_W-1:0]    out_message_out,
  output logic [SENT_W-1:0]   out_sent_count,
  output logic [NUM_CPUS-1:0] out_raised_mask,
  output logic [IDX_W-1:0]    out_handler_index,
  output logic                out_handler_valid,
  output logic                out_last
);

  // captured request
  req_t                req_r;
  logic [CPU_W-1:0]    cpu_r;
  logic [MSG_W-1:0]    msg_r;
  logic [NUM_CPUS-1:0] fail_r;
  logic                args_r;

  // mailbox state
  logic [NUM_CPUS-1:0] online_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [MSG_W-1:0]    pend_r   [NUM_CPUS];
  logic [MSG_W-1:0]    pend_nxt [NUM_CPUS];
  logic [MSG_W-1:0]    scan_r;

  // result register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [MSG_W-1:0]    out_msg_r;
  logic [SENT_W-1:0]   out_sent_r;
  logic [NUM_CPUS-1:0] out_raised_r;
  logic [IDX_W-1:0]    out_hidx_r;
  logic                out_hval_r;
  logic                out_last_r;

  // execute results
  status_t             res_status;
  logic [MSG_W-1:0]    res_msg;
  logic [SENT_W-1:0]   res_sent;
  logic [NUM_CPUS-1:0] res_raised;

  logic [MSG_W-1:0]    reg_mask;
  logic                msg_ok;
  logic [NUM_CPUS-1:0] tgt;
  logic [NUM_CPUS-1:0] act;
  logic [NUM_CPUS-1:0] raised;
  logic [CPU_W:0]      raised_cnt;

  logic [MSG_W-1:0]    scan_low;
  logic [MSG_W-1:0]    scan_rest;
  logic [IDX_W-1:0]    scan_idx;

  // message must be one-hot and below the registered count
  always_comb begin
    if (count_r >= CNT_W'(MSG_W)) begin
      reg_mask = '1;
    end else begin
      reg_mask = (MSG_W'(1) << count_r[IDX_W-1:0]) - MSG_W'(1);
    end
    msg_ok = (msg_r != '0) && ((msg_r & (msg_r - MSG_W'(1))) == '0) &&
             ((msg_r & reg_mask) != '0);
  end

  // per-cpu delivery lanes
  always_comb begin
    for (int c = 0; c < NUM_CPUS; c++) begin
      if (req_r == REQ_SEND) begin
        tgt[c] = (CPU_W'(c) == cpu_r);
      end else begin
        tgt[c] = (CPU_W'(c) != cpu_r);
      end
    end
    act        = tgt & online_r;
    raised     = act & ~fail_r;
    raised_cnt = '0;
    for (int c = 0; c < NUM_CPUS; c++) begin
      raised_cnt = raised_cnt + (CPU_W+1)'(raised[c]);
    end
  end

  // lowest pending bit of the dispatch word
  always_comb begin
    scan_low  = scan_r & (~scan_r + MSG_W'(1));
    scan_rest = scan_r & ~scan_low;
    scan_idx  = '0;
    for (int i = 0; i < MSG_W; i++) begin
      if (scan_low[i]) begin
        scan_idx = scan_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    pend_nxt   = pend_r;
    count_nxt  = count_r;
    res_status = ST_OK;
    res_msg    = '0;
    res_sent   = '0;
    res_raised = '0;
    if (cmd.exec_op) begin
      case (req_r)
        REQ_REGISTER: begin
          if (!args_r) begin
            res_status = ST_INVALID;
          end else if (count_r >= CNT_W'(NUM_MESSAGES)) begin
            res_status = ST_FULL;
          end else begin
            res_msg   = MSG_W'(1) << count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_SEND, REQ_BROADCAST: begin
          if (!msg_ok) begin
            res_status = ST_INVALID;
          end else if ((req_r == REQ_SEND) && !online_r[cpu_r]) begin
            res_status = ST_OFFLINE;
          end else begin
            for (int c = 0; c < NUM_CPUS; c++) begin
              if (act[c]) begin
                if (fail_r[c]) begin
                  pend_nxt[c] = pend_r[c] & ~msg_r;
                end else begin
                  pend_nxt[c] = pend_r[c] | msg_r;
                end
              end
            end
            res_raised = raised;
            if (req_r == REQ_SEND) begin
              if (fail_r[cpu_r]) begin
                res_status = ST_RAISE_FAIL;
              end
            end else begin
              res_sent = raised_cnt[SENT_W-1:0];
            end
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
    if (cmd.load_scan) begin
      pend_nxt[cpu_r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CPUS; c++) begin
        pend_r[c] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        online_r <= cfg_online_mask;
      end
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      if (cmd.exec_op || cmd.emit_scan) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_t'(in_req_type);
      cpu_r  <= in_cpu;
      msg_r  <= in_msg_bits;
      fail_r <= in_raise_fail_mask;
      args_r <= in_args_valid;
    end
    if (cmd.load_scan) begin
      scan_r <= pend_r[cpu_r];
    end else if (cmd.emit_scan) begin
      scan_r <= scan_rest;
    end
    if (cmd.exec_op) begin
      out_status_r <= res_status;
      out_msg_r    <= res_msg;
      out_sent_r   <= res_sent;
      out_raised_r <= res_raised;
      out_hidx_r   <= '0;
      out_hval_r   <= 1'b0;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_scan) begin
      out_status_r <= ST_OK;
      out_msg_r    <= '0;
      out_sent_r   <= '0;
      out_raised_r <= '0;
      out_hidx_r   <= scan_idx;
      out_hval_r   <= (scan_r != '0);
      out_last_r   <= (scan_rest == '0);
    end
  end

  always_comb begin
    sts.is_dispatch = (req_r == REQ_DISPATCH);
    sts.slot_free   = !out_valid_r || out_ready;
    sts.scan_last   = (scan_rest == '0);
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_message_out   = out_msg_r;
  assign out_sent_count    = out_sent_r;
  assign out_raised_mask   = out_raised_r;
  assign out_handler_index = out_hidx_r;
  assign out_handler_valid = out_hval_r;
  assign out_last          = out_last_r;

endmodule

@@ sv/ipi_mailbox_pending_dispatch.sv @@
// ----------------------------------------------------------------------------
// ipi_mailbox_pending_dispatch
// inter-processor mailbox with per-cpu pending words and dispatch scan-out
// ----------------------------------------------------------------------------
// requests enter on the in_ channel (valid/ready), results leave on the out_
// channel (valid/ready); cfg_ writes the online mask and is always ready.
// a request is taken only while the block is idle. the exec state then
// executes it; a register, send or broadcast result is written into the
// output register there, while a dispatch captures the pending word and the
// scan state emits its results. register, send and broadcast give one
// result; a dispatch gives n results (n >= 1), one result per cycle while
// the receiver does not stall, from the lowest-set-bit scan of the captured
// pending word. broadcast updates the lanes of all online cpus but in_cpu in
// the execute cycle. when the receiver stalls, the scan and non-dispatch
// execution hold until the output register is free; no new request is taken.
// synchronous reset clears all pending words, the slot count, the online mask
// and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "ipi_mailbox_pending_dispatch_assert.svh"

module ipi_mailbox_pending_dispatch import ipimb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [NUM_CPUS-1:0] cfg_online_mask,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [CPU_W-1:0]    in_cpu,
  input  logic [MSG_W-1:0]    in_msg_bits,
  input  logic [NUM_CPUS-1:0] in_raise_fail_mask,
  input  logic                in_args_valid,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [MSG_W-1:0]    out_message_out,
  output logic [SENT_W-1:0]   out_sent_count,
  output logic [NUM_CPUS-1:0] out_raised_mask,
  output logic [IDX_W-1:0]    out_handler_index,
  output logic                out_handler_valid,
  output logic                out_last
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ipimb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipimb_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_online_mask    (cfg_online_mask),
    .in_req_type        (in_req_type),
    .in_cpu             (in_cpu),
    .in_msg_bits        (in_msg_bits),
    .in_raise_fail_mask (in_raise_fail_mask),
    .in_args_valid      (in_args_valid),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_message_out    (out_message_out),
    .out_sent_count     (out_sent_count),
    .out_raised_mask    (out_raised_mask),
    .out_handler_index  (out_handler_index),
    .out_handler_valid  (out_handler_valid),
    .out_last           (out_last)
  );

  // busy right after a request is taken
  `IPIMB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // failed requests give a single result that raised nothing
  `IPIMB_ASSERT_IMPL(a_fail_single, out_valid && (out_status != ST_OK),
                     out_last && (out_raised_mask == '0) && !out_handler_valid)
  // a handed-out message bit only comes with ok status
  `IPIMB_ASSERT_IMPL(a_msg_ok, out_valid && (out_message_out != '0),
                     (out_status == ST_OK) && (out_sent_count == '0))

endmodule
